// ===== rtl/core/heq_pkg.sv =====
// Shared types and constants of the histogram equaliser.
package heq_pkg;

   // Default geometry of the histogram.
   localparam int DEF_LEVELS     = 256;
   localparam int DEF_COUNT_BITS = 22;

   // Fixed widths of the transaction fields.
   localparam int PIXEL_BITS = 8;

   // Largest output grey level; also the scale factor of the map.
   localparam logic [PIXEL_BITS-1:0] OUT_MAX = 8'd255;

   // Depth of the queue between the front and back parts (power of two).
   localparam int QUEUE_DEPTH = 4;

   // Number of quotient bits the divider produces (8 value bits plus overflow).
   localparam int QUOT_BITS = PIXEL_BITS + 1;

   // What a queued transaction asks the back part to do.
   typedef enum logic {
      OP_COUNT = 1'b0,
      OP_MAP   = 1'b1
   } op_type;

   // One classified transaction as it waits in the queue.
   typedef struct packed {
      op_type                op;
      logic                  last;
      logic [PIXEL_BITS-1:0] level;
   } item_type;

endpackage

// ===== rtl/core/heq_req_if.sv =====
// Request channel carrying pixels into the equaliser.
interface heq_req_if import heq_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  is_last;

   modport source (output valid, output action, output pixel, output is_last, input ready);
   modport sink   (input valid, input action, input pixel, input is_last, output ready);

endinterface

// ===== rtl/core/heq_rsp_if.sv =====
// Response channel carrying equalised pixels out of the equaliser.
interface heq_rsp_if import heq_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] mapped_pixel;

   modport source (output valid, output mapped_pixel, input ready);
   modport sink   (input valid, input mapped_pixel, output ready);

endinterface

// ===== rtl/core/heq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module heq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ===== rtl/core/heq_front.sv =====
// Front part: accepts pixel transactions, classifies them and queues them.
module heq_front import heq_pkg::*; #(
   parameter int LEVELS = DEF_LEVELS
) (
   input  logic      clock,
   input  logic      reset,
   heq_req_if.sink   req,
   output logic      head_valid,
   output item_type  head_item,
   input  logic      pop
);

   localparam int QPB = $clog2(QUEUE_DEPTH);
   localparam logic [PIXEL_BITS-1:0] TOP_LEVEL = PIXEL_BITS'(LEVELS - 1);

   item_type         queue_ff [QUEUE_DEPTH];
   logic [QPB-1:0]   head_ff, head_in;
   logic [QPB-1:0]   tail_ff, tail_in;
   logic [QPB:0]     count_ff, count_in;
   logic             push;
   item_type         new_item;

   // Classify the incoming pixel; levels beyond the top one fold onto it.
   always_comb begin
      new_item.op    = req.action ? OP_MAP : OP_COUNT;
      new_item.last  = req.is_last;
      new_item.level = (req.pixel > TOP_LEVEL) ? TOP_LEVEL : req.pixel;
   end

   assign req.ready  = (count_ff != (QPB + 1)'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = queue_ff[head_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + QPB'(1);
      end
      if (pop) begin
         head_in = head_ff + QPB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QPB + 1)'(1);
      end else if (!push && pop) begin
         count_in = count_ff - (QPB + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/core/heq_div.sv =====
// Restoring divider producing one saturated 8-bit map entry, one bit a cycle.
module heq_div import heq_pkg::*; #(
   parameter int DIVIDEND_BITS = 38,
   parameter int DIVISOR_BITS  = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done_ff,
   output logic [PIXEL_BITS-1:0]    quotient
);

   localparam int SB = $clog2(QUOT_BITS);

   logic [DIVIDEND_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0]     quo_ff, quo_in;
   logic [SB-1:0]            step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic                     done_in;
   logic [DIVIDEND_BITS-1:0] shifted;
   logic                     fits;

   // One trial subtraction of the divisor scaled by the current bit weight.
   assign shifted = DIVIDEND_BITS'(divisor) << step_ff;
   assign fits    = (rem_ff >= shifted);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         quo_in  = '0;
         step_in = SB'(QUOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - shifted;
         end
         quo_in = {quo_ff[QUOT_BITS-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - SB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   // A quotient of 256 or more means the entry saturates at the top level.
   assign quotient = quo_ff[QUOT_BITS-1] ? OUT_MAX : quo_ff[PIXEL_BITS-1:0];

   // The done flag follows the start pulse once every quotient bit has been produced.
   assert property (@(posedge clock) disable iff (reset) start |-> ##(QUOT_BITS + 1) done_ff)
      else $error("divider result did not arrive on time");

endmodule

// ===== rtl/core/heq_back.sv =====
// Back part: updates the histogram, builds the level map and maps pixels.
module heq_back import heq_pkg::*; #(
   parameter int LEVELS     = DEF_LEVELS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       pop,
   heq_rsp_if.source  rsp
);

   localparam int LB = $clog2(LEVELS);
   localparam int CW = COUNT_BITS + LB;
   localparam int PB = CW + PIXEL_BITS;
   localparam logic [LB-1:0] LAST_LEVEL = LB'(LEVELS - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_COUNT = 7'b0000010,
      S_MAP   = 7'b0000100,
      S_BREAD = 7'b0001000,
      S_BACC  = 7'b0010000,
      S_BMUL  = 7'b0100000,
      S_BDIV  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [LEVELS-1:0]       valid_ff, valid_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [LB-1:0]           lvl_ff, lvl_in;
   logic [CW-1:0]           cum_ff, cum_in;
   logic                    last_ff, last_in;
   logic [LB-1:0]           level_ff, level_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                    hist_we;
   logic [LB-1:0]           hist_raddr;
   logic [COUNT_BITS-1:0]   hist_rdata;
   logic [COUNT_BITS-1:0]   hist_wdata;
   logic [COUNT_BITS-1:0]   bin_sel;
   logic [LB-1:0]           bin_idx;
   logic                    map_we;
   logic [LB-1:0]           map_raddr;
   logic [PIXEL_BITS-1:0]   map_rdata;
   logic [PIXEL_BITS-1:0]   map_wdata;
   logic                    div_start;
   logic                    div_done;
   logic [PIXEL_BITS-1:0]   div_q;
   logic [PB-1:0]           scaled_cum;
   logic                    out_load;

   // Histogram bins; an entry whose valid bit is clear reads as zero.
   heq_ram #(.WIDTH(COUNT_BITS), .DEPTH(LEVELS)) u_hist (
      .clock    (clock),
      .we       (hist_we),
      .waddr    (level_ff),
      .wdata    (hist_wdata),
      .raddr    (hist_raddr),
      .rdata_ff (hist_rdata)
   );

   // Level map written by the map build.
   heq_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LEVELS)) u_map (
      .clock    (clock),
      .we       (map_we),
      .waddr    (lvl_ff),
      .wdata    (map_wdata),
      .raddr    (map_raddr),
      .rdata_ff (map_rdata)
   );

   // Shared divider for cumulative count times 255 over the total.
   heq_div #(.DIVIDEND_BITS(PB), .DIVISOR_BITS(COUNT_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled_cum),
      .divisor  (total_ff),
      .done_ff  (div_done),
      .quotient (div_q)
   );

   // Read addresses follow the queue head while idle, else the current work.
   always_comb begin
      if (state_ff == S_IDLE) begin
         hist_raddr = head_item.level[LB-1:0];
         map_raddr  = head_item.level[LB-1:0];
      end else if (state_ff == S_BREAD) begin
         hist_raddr = lvl_ff;
         map_raddr  = level_ff;
      end else begin
         hist_raddr = level_ff;
         map_raddr  = level_ff;
      end
   end

   // Bin value seen by the count update and by the accumulation step.
   assign bin_idx    = (state_ff == S_BACC) ? lvl_ff : level_ff;
   assign bin_sel    = valid_ff[bin_idx] ? hist_rdata : '0;
   assign hist_wdata = (bin_sel == '1) ? bin_sel : bin_sel + COUNT_BITS'(1);

   // Multiplication by 255 as a shift and a subtraction.
   assign scaled_cum = (PB'(cum_ff) << PIXEL_BITS) - PB'(cum_ff);
   assign map_wdata  = (total_ff == '0) ? '0 : div_q;

   // The output register takes a mapped pixel when it is empty or draining.
   assign out_load = (state_ff == S_MAP) && (!rsp_valid_ff || rsp.ready);

   // Sequencer of the back part.
   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      total_in  = total_ff;
      lvl_in    = lvl_ff;
      cum_in    = cum_ff;
      last_in   = last_ff;
      level_in  = level_ff;
      pop       = 1'b0;
      hist_we   = 1'b0;
      map_we    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               last_in  = head_item.last;
               level_in = head_item.level[LB-1:0];
               state_in = (head_item.op == OP_MAP) ? S_MAP : S_COUNT;
            end
         end
         S_COUNT: begin
            hist_we            = 1'b1;
            valid_in[level_ff] = 1'b1;
            total_in = (total_ff == '1) ? total_ff : total_ff + COUNT_BITS'(1);
            if (last_ff) begin
               lvl_in   = '0;
               cum_in   = '0;
               state_in = S_BREAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAP: begin
            if (out_load) begin
               if (last_ff) begin
                  valid_in = '0;
                  total_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         S_BREAD: begin
            state_in = S_BACC;
         end
         S_BACC: begin
            cum_in   = cum_ff + CW'(bin_sel);
            state_in = S_BMUL;
         end
         S_BMUL: begin
            div_start = 1'b1;
            state_in  = S_BDIV;
         end
         S_BDIV: begin
            if (div_done) begin
               map_we = 1'b1;
               if (lvl_ff == LAST_LEVEL) begin
                  state_in = S_IDLE;
               end else begin
                  lvl_in   = lvl_ff + LB'(1);
                  state_in = S_BREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register in front of the response channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = map_rdata;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mapped_pixel = rsp_data_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload.
   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      cum_ff      <= cum_in;
      last_ff     <= last_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A saturating increment never writes a zero bin.
   assert property (@(posedge clock) disable iff (reset) hist_we |-> (hist_wdata != '0))
      else $error("bin update wrote zero");

   // Once a pixel has been counted the total cannot be zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COUNT) |=> (total_ff != '0))
      else $error("pixel total zero after a count");

   // The last mapped pixel of a frame leaves a cleared histogram behind.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> (total_ff == '0 && valid_ff == '0))
      else $error("histogram not cleared after the last map transaction");

   // The map build starts from an empty cumulative sum.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BREAD && lvl_ff == '0) |-> (cum_ff == '0))
      else $error("map build started with a stale cumulative count");

endmodule

// ===== rtl/core/histogram_equalizer_unit.sv =====
// Top level of the grey-level histogram equaliser.
//
// Pixel transactions arrive on req_ch (action, pixel, is_last) and mapped
// pixels leave on rsp_ch (mapped_pixel), both with a valid/ready handshake.
// A count transaction (action 0) adds its pixel to the histogram and the
// pixel total and returns nothing; the one marked last starts the map build.
// A map transaction (action 1) returns the equalised level of its pixel; the
// one marked last clears the histogram and the total afterwards.
// A four-entry queue decouples acceptance from the back part, which handles
// one transaction at a time, in the idle state and then the count or map
// state, so as to allow for the registered read of the bin and map RAMs.
// Per level the map build reads the bin, accumulates it, starts the 9-step
// divider and writes the entry; transactions queue up meanwhile. A map result
// leaves through the registered map read and the output register to rsp_ch.
// Reset empties the queue and the output register and clears the histogram
// at once through per-bin valid bits; the level map is undefined until the
// first build. When the receiver stalls, the result waits in the output
// register while count transactions carry on; a further map transaction
// waits in the back part and the queue fills until req_ch.ready drops.
module histogram_equalizer_unit import heq_pkg::*; #(
   parameter int LEVELS     = DEF_LEVELS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   heq_req_if.sink     req_ch,
   heq_rsp_if.source   rsp_ch
);

   logic     head_valid;
   item_type head_item;
   logic     pop;

   // Acceptance, classification and queueing.
   heq_front #(.LEVELS(LEVELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   // Histogram update, map build and pixel mapping.
   heq_back #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule
